FILE: rtl/core/dds_pkg.sv
// dds_pkg: shared types, constants and the sine table of the tone generator
// used by dds_front, dds_fifo, dds_back and dds_sine_tone_generator
`default_nettype none

package dds_pkg;

  // table and phase geometry
  localparam int TABLE_DEPTH = 256;
  localparam int TABLE_BITS  = $clog2(TABLE_DEPTH);
  localparam int PHASE_FRAC  = 16;
  localparam int PHASE_W     = TABLE_BITS + PHASE_FRAC;

  // field and register widths
  localparam int STEP_W   = 24;
  localparam int PERIOD_W = 17;
  localparam int VOL_W    = 12;
  localparam int SAMPLE_W = 15;
  localparam int LEVEL_W  = 15;
  localparam int SCALE_SH = 16;
  localparam int X_W      = SAMPLE_W + PERIOD_W - SCALE_SH;
  localparam int PROD_W   = X_W + VOL_W;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = STEP_W;
  localparam logic [STEP_W-1:0]   STEP_RESET   = STEP_W'(369098);
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(50);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TONE_STEP  = 1'b0,
    CFG_PWM_PERIOD = 1'b1
  } cfg_reg_t;

  // scaling constants
  localparam int SINE_AMP  = 16383;
  localparam int SINE_MID  = 16384;
  localparam int VOL_FULL  = (1 << VOL_W) - 1;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};

  // beat widths
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  // one queued tick: table index, volume and tone state
  typedef struct packed {
    logic [TABLE_BITS-1:0] idx;
    logic [VOL_W-1:0]      volume;
    logic                  playing;
  } dds_item_t;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // sine table, built at elaboration
  typedef logic [SAMPLE_W-1:0] sine_rom_t [TABLE_DEPTH];

  localparam real PI = 3.14159265358979323846;

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    real       val;
    int        i;
    for (i = 0; i < TABLE_DEPTH; i++) begin
      if (i == 0 || 2 * i == TABLE_DEPTH) begin
        rom[i] = SAMPLE_W'(SINE_MID);
      end else if (4 * i == TABLE_DEPTH) begin
        rom[i] = SAMPLE_W'(SINE_MID + SINE_AMP);
      end else if (4 * i == 3 * TABLE_DEPTH) begin
        rom[i] = SAMPLE_W'(SINE_MID - SINE_AMP);
      end else begin
        val = real'(SINE_MID) + real'(SINE_AMP) * $sin(2.0 * PI * real'(i) / TABLE_DEPTH);
        rom[i] = SAMPLE_W'($rtoi(val));
      end
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

FILE: rtl/core/dds_front.sv
// dds_front: accepts tick beats, tracks the alarm edge and advances the phase
// depends on dds_pkg; feeds dds_fifo
`default_nettype none

module dds_front (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           tick_valid,
  output logic                          tick_ready,
  input  wire                           alarm_on,
  input  wire  [dds_pkg::VOL_W-1:0]     volume,
  input  wire  [dds_pkg::STEP_W-1:0]    tone_step,
  output logic                          push,
  input  wire                           q_full,
  output dds_pkg::dds_item_t            push_item
);
  import dds_pkg::*;

  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic               active_r, active_nxt;

  // take a beat whenever the queue has room
  assign tick_ready = !q_full;
  assign push       = tick_valid && !q_full;

  // phase stays at zero while silent, so a rising edge starts from zero
  always_comb begin
    active_nxt = active_r;
    phase_nxt  = phase_r;
    if (push) begin
      active_nxt = alarm_on;
      phase_nxt  = alarm_on ? PHASE_W'(phase_r + PHASE_W'(tone_step)) : '0;
    end
  end

  assign push_item.idx     = phase_nxt[PHASE_W-1 -: TABLE_BITS];
  assign push_item.volume  = volume;
  assign push_item.playing = alarm_on;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= '0;
      active_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      active_r <= active_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/dds_fifo.sv
// dds_fifo: short queue of ticks between the front and the back
// depends on dds_pkg
`default_nettype none

module dds_fifo (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  dds_pkg::dds_item_t  push_item,
  output logic                full,
  input  wire                 pop,
  output logic                not_empty,
  output dds_pkg::dds_item_t  pop_item
);
  import dds_pkg::*;

  dds_item_t          mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   count_r, count_nxt;

  assign full      = (count_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_item  = mem_r[rd_ptr_r];

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  // storage needs no reset
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("queue count beyond depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("pop from empty queue");
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + 1'b1)
    else $error("push did not grow the queue");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/dds_back.sv
// dds_back: table lookup, two scaling multiplies, divide by full volume, output register
// depends on dds_pkg; drains dds_fifo
`default_nettype none

module dds_back (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             q_not_empty,
  input  dds_pkg::dds_item_t              q_item,
  output logic                            pop,
  input  wire  [dds_pkg::PERIOD_W-1:0]    pwm_period,
  output logic                            res_valid,
  input  wire                             res_ready,
  output logic [dds_pkg::LEVEL_W-1:0]     pwm_level,
  output logic                            playing
);
  import dds_pkg::*;

  logic en;

  // stage 1: sine sample
  logic                v1_r;
  logic [SAMPLE_W-1:0] s1_sample_r;
  logic [VOL_W-1:0]    s1_vol_r;
  logic                s1_play_r;

  // stage 2: sample scaled by period
  logic                v2_r;
  logic [X_W-1:0]      s2_x_r;
  logic [VOL_W-1:0]    s2_vol_r;
  logic                s2_play_r;

  // stage 3: scaled sample times volume
  logic                v3_r;
  logic [PROD_W-1:0]   s3_prod_r;
  logic                s3_play_r;

  // output register
  logic                out_valid_r;
  logic [LEVEL_W-1:0]  level_r, level_nxt;
  logic                play_r;

  logic [SAMPLE_W+PERIOD_W-1:0] mul_a;
  logic [PROD_W-1:0]            mul_b;

  // division by full volume: p = a*2^w + b, p/(2^w-1) = a + (a+b)/(2^w-1)
  logic [X_W-1:0]        div_a;
  logic [VOL_W-1:0]      div_b;
  logic [X_W:0]          div_c;
  logic [X_W-VOL_W:0]    div_a2;
  logic [VOL_W-1:0]      div_b2;
  logic [VOL_W:0]        div_d;
  logic                  div_corr;
  logic [X_W+1:0]        div_q;

  // whole pipeline moves when the output slot frees up
  assign en  = !out_valid_r || res_ready;
  assign pop = en && q_not_empty;

  assign mul_a = (SAMPLE_W+PERIOD_W)'(s1_sample_r) * (SAMPLE_W+PERIOD_W)'(pwm_period);
  assign mul_b = PROD_W'(s2_x_r) * PROD_W'(s2_vol_r);

  always_comb begin
    div_a    = s3_prod_r[PROD_W-1:VOL_W];
    div_b    = s3_prod_r[VOL_W-1:0];
    div_c    = (X_W+1)'(div_a) + (X_W+1)'(div_b);
    div_a2   = div_c[X_W:VOL_W];
    div_b2   = div_c[VOL_W-1:0];
    div_d    = (VOL_W+1)'(div_a2) + (VOL_W+1)'(div_b2);
    div_corr = (div_d >= (VOL_W+1)'(VOL_FULL));
    div_q    = (X_W+2)'(div_a) + (X_W+2)'(div_a2) + (X_W+2)'(div_corr);
    if (!s3_play_r) begin
      level_nxt = '0;
    end else if (div_q > (X_W+2)'(LEVEL_MAX)) begin
      level_nxt = LEVEL_MAX;
    end else begin
      level_nxt = div_q[LEVEL_W-1:0];
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= pop;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (en) begin
      s1_sample_r <= SINE_ROM[q_item.idx];
      s1_vol_r    <= q_item.volume;
      s1_play_r   <= q_item.playing;
      s2_x_r      <= mul_a[SAMPLE_W+PERIOD_W-1:SCALE_SH];
      s2_vol_r    <= s1_vol_r;
      s2_play_r   <= s1_play_r;
      s3_prod_r   <= mul_b;
      s3_play_r   <= s2_play_r;
      level_r     <= level_nxt;
      play_r      <= s3_play_r;
    end
  end

  assign res_valid = out_valid_r;
  assign pwm_level = level_r;
  assign playing   = play_r;

`ifndef SYNTHESIS
  a_silent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !play_r |-> level_r == '0)
    else $error("silent beat with nonzero level");
  a_pop_fills: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> v1_r)
    else $error("popped tick lost in stage one");
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v3_r) && $stable(s3_prod_r) && $stable(v2_r))
    else $error("pipeline moved during stall");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/dds_sine_tone_generator.sv
// dds_sine_tone_generator: top level of the sine tone generator
// depends on dds_pkg, dds_front, dds_fifo, dds_back
//
// channel  direction  tdata fields (lsb first)          notes
// in_      slave      alarm_on[0], volume[12:1], pad   one tick per beat
// out_     master     pwm_level[14:0], playing[15]     one result per tick
// cfg_     write      index 0 tone_step, 1 pwm_period  no read-back
//
// one tick per cycle sustained while the output takes results; a taken tick passes through
// the queue, table read, period multiply, volume multiply, divide and output register;
// the four-entry queue lets ticks be taken while the output stalls; reset leaves
// the tone silent, phase at zero and registers at their defaults; no clearing pass
`default_nettype none

module dds_sine_tone_generator (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire  [dds_pkg::IN_DATA_W-1:0]    in_tdata,   // alarm_on, volume
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [dds_pkg::OUT_DATA_W-1:0]   out_tdata,  // pwm_level, playing
  input  wire                              cfg_we,
  input  wire  [dds_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [dds_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import dds_pkg::*;

  logic [STEP_W-1:0]   tone_step_r;
  logic [PERIOD_W-1:0] pwm_period_r;

  logic      push, q_full, pop, q_not_empty;
  dds_item_t push_item, pop_item;

  logic [LEVEL_W-1:0] pwm_level;
  logic               playing;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone_step_r  <= STEP_RESET;
      pwm_period_r <= PERIOD_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_TONE_STEP:  tone_step_r  <= cfg_wdata[STEP_W-1:0];
        CFG_PWM_PERIOD: pwm_period_r <= cfg_wdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  dds_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick_valid (in_tvalid),
    .tick_ready (in_tready),
    .alarm_on   (in_tdata[0]),
    .volume     (in_tdata[VOL_W:1]),
    .tone_step  (tone_step_r),
    .push       (push),
    .q_full     (q_full),
    .push_item  (push_item)
  );

  dds_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .pop_item  (pop_item)
  );

  dds_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_item      (pop_item),
    .pop         (pop),
    .pwm_period  (pwm_period_r),
    .res_valid   (out_tvalid),
    .res_ready   (out_tready),
    .pwm_level   (pwm_level),
    .playing     (playing)
  );

  // result beat packing
  assign out_tdata = {playing, pwm_level};

endmodule

`default_nettype wire
